@@ rtl/pmdc_pkg.sv @@
// ----------------------------------------------------------------------------
// pmdc_pkg - shared types and constants for the prefix-min dominance counter
// Node and entry formats, sequencer states and the finish handshake struct.
// ----------------------------------------------------------------------------
package pmdc_pkg;

  localparam int TREE_SIZE_DEF = 1024;
  localparam int NODE_W        = 17;
  localparam int STR_W         = 16;
  localparam int RANK_W        = 11;
  localparam int COUNT_W       = 11;
  localparam int EPOCH_W       = 8;

  localparam logic [NODE_W-1:0]  EMPTY_NODE = {NODE_W{1'b1}};
  localparam logic [COUNT_W-1:0] COUNT_MAX  = {COUNT_W{1'b1}};
  localparam logic [EPOCH_W-1:0] EPOCH_MAX  = {EPOCH_W{1'b1}};

  typedef struct packed {
    logic [EPOCH_W-1:0] tag;
    logic [NODE_W-1:0]  val;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLR,
    S_QLO,
    S_QHI,
    S_DECIDE,
    S_UP,
    S_UPW,
    S_FIN
  } seq_state_t;

  typedef struct packed {
    logic valid;
    logic best;
    logic new_set;
  } fin_t;

  function automatic logic [NODE_W-1:0] node_val(entry_t e, logic [EPOCH_W-1:0] epoch);
    return (e.tag == epoch) ? e.val : EMPTY_NODE;
  endfunction

  function automatic logic [NODE_W-1:0] node_min(logic [NODE_W-1:0] a,
                                                 logic [NODE_W-1:0] b);
    return (a < b) ? a : b;
  endfunction

endpackage

@@ rtl/pmdc_tree_mem.sv @@
// ----------------------------------------------------------------------------
// pmdc_tree_mem - min tree node storage
// Simple dual-port synchronous RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module pmdc_tree_mem #(
  parameter int DEPTH = 2048,
  parameter int AW    = 11,
  parameter int W     = 25
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [W-1:0]  wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [W-1:0]  rd_data
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ rtl/pmdc_seq.sv @@
// ----------------------------------------------------------------------------
// pmdc_seq - tree walk sequencer
// Runs the clearing sweep, the bottom-up prefix-min query and the root-path
// update against the node memory, one item at a time.
// ----------------------------------------------------------------------------
module pmdc_seq #(
  parameter int TREE_SIZE = pmdc_pkg::TREE_SIZE_DEF,
  parameter int AW        = $clog2(2 * TREE_SIZE)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  input  logic                          new_set,
  input  logic [pmdc_pkg::RANK_W-1:0]   rank,
  input  logic [pmdc_pkg::STR_W-1:0]    strength,
  output logic                          busy,
  output logic                          rd_en,
  output logic [AW-1:0]                 rd_addr,
  input  logic [pmdc_pkg::ENTRY_W-1:0]  rd_data,
  output logic                          wr_en,
  output logic [AW-1:0]                 wr_addr,
  output logic [pmdc_pkg::ENTRY_W-1:0]  wr_data,
  output pmdc_pkg::fin_t                fin,
  input  logic                          fin_ack
);

  import pmdc_pkg::*;

  localparam int LW    = $clog2(2 * TREE_SIZE + 1);
  localparam int RW    = $clog2(TREE_SIZE + 1);
  localparam int DEPTH = 2 * TREE_SIZE;

  seq_state_t state, state_next;

  logic [LW-1:0]      lo, hi;
  logic [LW-1:0]      lo_step, hi_step;
  logic [AW-1:0]      node;
  logic [AW-1:0]      clr_idx;
  logic [NODE_W-1:0]  best_min;
  logic [STR_W-1:0]   strength_q;
  logic [RW-1:0]      rank_q;
  logic [RW-1:0]      rank_sat;
  logic               new_set_q;
  logic               is_best_q;
  logic               item_held;
  logic               rd_pend;
  logic [EPOCH_W-1:0] epoch;
  logic               accept;
  logic               clr_last;
  logic               found_best;
  logic [NODE_W-1:0]  rd_val;
  entry_t             wr_entry;

  assign accept     = item_valid && (state == S_IDLE);
  assign clr_last   = (clr_idx == AW'(DEPTH - 1));
  assign rank_sat   = (32'(rank) > TREE_SIZE) ? RW'(TREE_SIZE) : RW'(rank);
  assign found_best = best_min > {1'b0, strength_q};
  assign rd_val     = node_val(entry_t'(rd_data), epoch);
  assign lo_step    = lo + LW'(lo[0]);
  assign hi_step    = hi - LW'(hi[0]);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = (new_set && (epoch == EPOCH_MAX)) ? S_CLR : S_QLO;
        end
      end
      S_CLR: begin
        if (clr_last) begin
          state_next = item_held ? S_QLO : S_IDLE;
        end
      end
      S_QLO:    state_next = (lo < hi) ? S_QHI : S_DECIDE;
      S_QHI:    state_next = S_QLO;
      S_DECIDE: state_next = (found_best && (rank_q != '0)) ? S_UP : S_FIN;
      S_UP:     state_next = S_UPW;
      S_UPW: begin
        if (node <= AW'(1)) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (fin_ack) begin
          state_next = S_IDLE;
        end
      end
      default:  state_next = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    busy         = (state != S_IDLE);
    rd_en        = 1'b0;
    rd_addr      = node;
    wr_en        = 1'b0;
    wr_addr      = node;
    wr_entry.tag = epoch;
    wr_entry.val = node_min(rd_val, {1'b0, strength_q});
    fin.valid    = (state == S_FIN);
    fin.best     = is_best_q;
    fin.new_set  = new_set_q;
    unique case (state)
      S_CLR: begin
        wr_en        = 1'b1;
        wr_addr      = clr_idx;
        wr_entry.tag = '0;
        wr_entry.val = EMPTY_NODE;
      end
      S_QLO: begin
        rd_en   = (lo < hi) && lo[0];
        rd_addr = lo[AW-1:0];
      end
      S_QHI: begin
        rd_en   = hi[0];
        rd_addr = hi_step[AW-1:0];
      end
      S_UP: begin
        rd_en = 1'b1;
      end
      S_UPW: begin
        wr_en   = 1'b1;
        rd_en   = (node > AW'(1));
        rd_addr = node >> 1;
      end
      default: begin
      end
    endcase
  end

  assign wr_data = wr_entry;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      clr_idx   <= '0;
      epoch     <= '0;
      item_held <= 1'b0;
      rd_pend   <= 1'b0;
    end else begin
      state   <= state_next;
      rd_pend <= rd_en && ((state == S_QLO) || (state == S_QHI));
      if (state == S_CLR) begin
        clr_idx <= clr_idx + AW'(1);
      end
      if (accept) begin
        item_held <= 1'b1;
        clr_idx   <= '0;
        if (new_set) begin
          epoch <= epoch + EPOCH_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_pend) begin
      best_min <= node_min(best_min, rd_val);
    end
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          strength_q <= strength;
          rank_q     <= rank_sat;
          new_set_q  <= new_set;
          lo         <= LW'(TREE_SIZE);
          hi         <= LW'(TREE_SIZE) + LW'(rank_sat);
          best_min   <= EMPTY_NODE;
        end
      end
      S_QLO: begin
        lo <= lo_step;
      end
      S_QHI: begin
        lo <= lo >> 1;
        hi <= hi_step >> 1;
      end
      S_DECIDE: begin
        is_best_q <= found_best;
        node      <= AW'(LW'(TREE_SIZE) + LW'(rank_q) - LW'(1));
      end
      S_UPW: begin
        node <= node >> 1;
      end
      default: begin
      end
    endcase
  end

  a_no_same_addr: assert property (@(posedge clk) disable iff (rst)
    (wr_en && rd_en) |-> (wr_addr != rd_addr))
    else $error("read and write hit the same node in one cycle");

  a_fold_after_query: assert property (@(posedge clk) disable iff (rst)
    rd_pend |-> ($past(state) == S_QLO || $past(state) == S_QHI))
    else $error("query data folded outside a query read");

  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (!rd_en && !wr_en && !rd_pend))
    else $error("memory access while idle");

  a_hi_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_QLO || state == S_QHI) |-> (hi <= LW'(DEPTH)))
    else $error("query bound beyond tree");

endmodule

@@ rtl/prefix_min_dominance_counter_unit.sv @@
// ----------------------------------------------------------------------------
// prefix_min_dominance_counter_unit - 3D non-dominated item counter
// Min tree over second ranks with prefix query, per-item best flag and count.
// ----------------------------------------------------------------------------
// An item is taken only while the unit is idle. It then runs the prefix-min
// query level by level (at most clog2(2*TREE_SIZE) levels, both query ends
// share the one read port of the node memory), sees the query end and takes
// its decision; a best item of nonzero rank then updates each node up the
// root path by read-modify-write, and the result is handed over last. The
// result sits in an output register, so the next item is taken while it
// waits. Sets are cleared by an epoch tag on each node; after reset and on
// every 256th new set the unit sweeps all 2*TREE_SIZE nodes, one per cycle,
// before work continues, and takes no item meanwhile.
module prefix_min_dominance_counter_unit #(
  parameter int TREE_SIZE = pmdc_pkg::TREE_SIZE_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  output logic                          item_stall,
  input  logic                          new_set,
  input  logic [pmdc_pkg::RANK_W-1:0]   rank,
  input  logic [pmdc_pkg::STR_W-1:0]    strength,
  output logic                          result_valid,
  input  logic                          result_stall,
  output logic                          is_best,
  output logic [pmdc_pkg::COUNT_W-1:0]  best_count
);

  import pmdc_pkg::*;

  localparam int AW    = $clog2(2 * TREE_SIZE);
  localparam int DEPTH = 2 * TREE_SIZE;

  logic               rd_en, wr_en;
  logic [AW-1:0]      rd_addr, wr_addr;
  logic [ENTRY_W-1:0] rd_data, wr_data;
  fin_t               fin;
  logic               fin_ack;
  logic               load;
  logic [COUNT_W-1:0] count;
  logic [COUNT_W-1:0] count_base;
  logic [COUNT_W-1:0] count_next;

  pmdc_tree_mem #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .W     (ENTRY_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  pmdc_seq #(
    .TREE_SIZE (TREE_SIZE),
    .AW        (AW)
  ) u_seq (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .new_set    (new_set),
    .rank       (rank),
    .strength   (strength),
    .busy       (item_stall),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .fin        (fin),
    .fin_ack    (fin_ack)
  );

  assign fin_ack    = !result_valid || !result_stall;
  assign load       = fin.valid && fin_ack;
  assign count_base = fin.new_set ? '0 : count;
  assign count_next = (fin.best && (count_base != COUNT_MAX)) ?
                      count_base + COUNT_W'(1) : count_base;

  always_ff @(posedge clk) begin
    if (rst) begin
      count        <= '0;
      result_valid <= 1'b0;
    end else begin
      if (load) begin
        count        <= count_next;
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      is_best    <= fin.best;
      best_count <= count_next;
    end
  end

endmodule

@@ tb/tb_prefix_min_dominance_counter_unit.sv @@
// ----------------------------------------------------------------------------
// tb_prefix_min_dominance_counter_unit - self-checking bench for the counter
// Drives ranked items through the unit and predicts each best flag and running
// count from a leaf-level copy of the stored strengths. Covers the extremes,
// rank zero, saturated ranks, ties, many set restarts and random sets under
// four sender and receiver idling patterns.
// ----------------------------------------------------------------------------
module tb_prefix_min_dominance_counter_unit;
  import pmdc_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 60;

  typedef struct packed {
    logic               best;
    logic [COUNT_W-1:0] count;
  } verdict_t;

  typedef enum int {DESCENDING, CLUSTERED, UNIFORM, NOISE} set_shape_t;

  logic               clk;
  logic               rst;
  logic               item_valid;
  logic               item_stall;
  logic               new_set;
  logic [RANK_W-1:0]  rank;
  logic [STR_W-1:0]   strength;
  logic               result_valid;
  logic               result_stall = 1'b0;
  logic               is_best;
  logic [COUNT_W-1:0] best_count;

  logic [NODE_W-1:0]  stored_strength [TREE_SIZE_DEF];
  logic [COUNT_W-1:0] best_tally;
  verdict_t           pending_verdicts [$];

  int idle_pct;
  int stall_pct;
  int error_count;
  int items_sent;
  int sets_started;
  int best_seen;
  int quiet_cycles;

  prefix_min_dominance_counter_unit DUT (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .new_set      (new_set),
    .rank         (rank),
    .strength     (strength),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .is_best      (is_best),
    .best_count   (best_count)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic void clear_dominance_state();
    for (int i = 0; i < TREE_SIZE_DEF; i++) stored_strength[i] = EMPTY_NODE;
    best_tally = '0;
  endfunction

  function automatic void predict_verdict(input logic ns, input logic [RANK_W-1:0] r,
                                          input logic [STR_W-1:0] s);
    int               pos;
    logic [NODE_W-1:0] floor_min;
    verdict_t         v;
    if (ns) clear_dominance_state();
    pos = (r > TREE_SIZE_DEF) ? TREE_SIZE_DEF : int'(r);
    floor_min = EMPTY_NODE;
    for (int i = 0; i < pos; i++)
      if (stored_strength[i] < floor_min) floor_min = stored_strength[i];
    v.best = floor_min > {1'b0, s};
    if (v.best) begin
      if (best_tally != COUNT_MAX) best_tally = best_tally + 1'b1;
      if (pos != 0) stored_strength[pos-1] = {1'b0, s};
    end
    v.count = best_tally;
    pending_verdicts.push_back(v);
  endfunction

  task automatic send_item(input logic ns, input logic [RANK_W-1:0] r,
                           input logic [STR_W-1:0] s);
    while ($urandom_range(0, 99) < idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    new_set    <= ns;
    rank       <= r;
    strength   <= s;
    predict_verdict(ns, r, s);
    items_sent++;
    if (ns) sets_started++;
    do @(posedge clk); while (item_stall);
  endtask

  // receiver stall
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      result_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // result check
  always @(posedge clk) begin
    verdict_t v;
    if (!rst && result_valid && !result_stall) begin
      if (pending_verdicts.size() == 0) begin
        $error("unexpected result: is_best %0d best_count %0d", is_best, best_count);
        error_count++;
      end else begin
        v = pending_verdicts.pop_front();
        if (is_best !== v.best) begin
          $error("is_best: expected %0d, actual %0d", v.best, is_best);
          error_count++;
        end
        if (best_count !== v.count) begin
          $error("best_count: expected %0d, actual %0d", v.count, best_count);
          error_count++;
        end
        if (is_best === 1'b1) best_seen++;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  task automatic test_directed_cases();
    idle_pct  = 0;
    stall_pct = 0;
    send_item(1'b0, 11'd1,    16'hFFFF);
    send_item(1'b0, 11'd1,    16'hFFFF);
    send_item(1'b0, 11'd2,    16'hFFFE);
    send_item(1'b0, 11'd0,    16'hFFFF);
    send_item(1'b0, 11'd1024, 16'h0000);
    send_item(1'b0, 11'd2047, 16'h0000);
    send_item(1'b0, 11'd1025, 16'h0001);
    send_item(1'b1, 11'd2047, 16'h0000);
    send_item(1'b0, 11'd1,    16'h0000);
    send_item(1'b0, 11'd512,  16'h0000);
    send_item(1'b0, 11'd0,    16'h0000);
    send_item(1'b1, 11'd1024, 16'hFFFF);
    send_item(1'b0, 11'd1023, 16'hFFFF);
    send_item(1'b0, 11'd1,    16'h8000);
    send_item(1'b0, 11'd3,    16'h7FFF);
    send_item(1'b0, 11'd3,    16'h7FFF);
    send_item(1'b0, 11'd1024, 16'h5555);
    send_item(1'b0, 11'd682,  16'h2AAA);
    send_item(1'b1, 11'd1,    16'h0000);
  endtask

  task automatic test_random_sets(input int item_total, input int idle, input int stall);
    int               sent;
    int               len;
    set_shape_t       shape;
    logic             ns;
    logic [RANK_W-1:0] r;
    logic [STR_W-1:0]  s;
    idle_pct  = idle;
    stall_pct = stall;
    sent = 0;
    while (sent < item_total) begin
      len   = $urandom_range(1, 8);
      shape = set_shape_t'($urandom_range(0, 3));
      s     = 16'($urandom_range(40000, 65535));
      for (int k = 0; k < len; k++) begin
        ns = (k == 0) && ($urandom_range(0, 7) != 0);
        case (shape)
          DESCENDING: begin
            r = 11'($urandom_range(1, TREE_SIZE_DEF));
            s = (s > 400) ? s - 16'($urandom_range(0, 400)) : s;
          end
          CLUSTERED: begin
            r = 11'($urandom_range(1, 6));
            s = 16'($urandom_range(0, 7));
          end
          UNIFORM: begin
            r = 11'($urandom_range(1, TREE_SIZE_DEF));
            s = 16'($urandom);
          end
          default: begin
            r = 11'($urandom);
            s = 16'($urandom);
            if ($urandom_range(0, 3) == 0) r = '0;
          end
        endcase
        send_item(ns, r, s);
        sent++;
      end
    end
  endtask

  initial begin
    rst          = 1'b1;
    item_valid   = 1'b0;
    new_set      = 1'b0;
    rank         = '0;
    strength     = '0;
    idle_pct     = 0;
    stall_pct    = 0;
    error_count  = 0;
    items_sent   = 0;
    sets_started = 0;
    best_seen    = 0;
    quiet_cycles = 0;
    clear_dominance_state();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_cases();
    test_random_sets(408, 0, 0);
    test_random_sets(408, 72, 0);
    test_random_sets(408, 0, 72);
    test_random_sets(408, 19, 19);

    item_valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (pending_verdicts.size() != 0) begin
      $error("%0d results never arrived", pending_verdicts.size());
      error_count++;
    end
    $display("Covered %0d items in %0d restarted sets, %0d of them reported best,",
             items_sent, sets_started, best_seen);
    $display("including rank zero, clamped ranks, ties and epoch sweeps.");
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
